// File: sv/wildcard_substring_matcher_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard substring matcher
// Shared same-cycle implication and next-cycle forms, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_SUBSTRING_MATCHER_TOP_MACROS_SVH
`define WILDCARD_SUBSTRING_MATCHER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wsm_pkg.sv
// ---------------------------------------------------------------------------
// Wildcard substring matcher package
// Shared constants, register indexes, word types and the case-fold helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsm_pkg;

  // Fixed sizes of the register file and the pattern store.
  localparam int PatternBytes      = 32;
  localparam int LenW              = 6;
  localparam int CfgDataW          = 64;
  localparam int CfgAddrW          = 6;
  localparam int PosOutW           = 8;

  // Defaults for the top-level parameters.
  localparam int MaxPatternDefault = 32;
  localparam int MaxTextDefault    = 256;

  // Character codes.
  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Register indexes (byte address is 8 times the index).
  typedef enum logic [2:0] {
    RegPat0  = 3'd0,
    RegPat1  = 3'd1,
    RegPat2  = 3'd2,
    RegPat3  = 3'd3,
    RegLen   = 3'd4,
    RegFold  = 3'd5
  } wsm_reg_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [PatternBytes*8-1:0] pattern;
    logic [LenW-1:0]           length;
    logic                      fold_case;
  } wsm_cfg_t;

  // Input word.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } wsm_in_word_t;

  // Result word.
  typedef struct packed {
    logic               match_found;
    logic [PosOutW-1:0] match_position;
  } wsm_out_word_t;

  // Map an upper-case ASCII letter to lower case when folding is enabled.
  function automatic logic [7:0] lower_byte(input logic [7:0] c, input logic fold);
    logic [7:0] r;
    r = c;
    if (fold && (c inside {[UpperA:UpperZ]})) begin
      r = c | CaseBit;
    end
    return r;
  endfunction

endpackage

// File: sv/wsm_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration register file
// APB-style write/read port holding the pattern, its length and case folding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wsm_pkg::CfgAddrW-1:0]      paddr,
  input  logic [wsm_pkg::CfgDataW-1:0]      pwdata,
  output logic [wsm_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready,
  output wsm_pkg::wsm_cfg_t                 cfg_o
);

  logic [wsm_pkg::CfgDataW-1:0] pat_q [4];
  logic [wsm_pkg::LenW-1:0]     len_q;
  logic                         fold_q;
  logic                         wr_en;
  wsm_pkg::wsm_reg_e            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = wsm_pkg::wsm_reg_e'(paddr[wsm_pkg::CfgAddrW-1:3]);

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q[0] <= '0;
      pat_q[1] <= '0;
      pat_q[2] <= '0;
      pat_q[3] <= '0;
      len_q    <= '0;
      fold_q   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        wsm_pkg::RegPat0: pat_q[0] <= pwdata;
        wsm_pkg::RegPat1: pat_q[1] <= pwdata;
        wsm_pkg::RegPat2: pat_q[2] <= pwdata;
        wsm_pkg::RegPat3: pat_q[3] <= pwdata;
        wsm_pkg::RegLen:  len_q    <= pwdata[wsm_pkg::LenW-1:0];
        wsm_pkg::RegFold: fold_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      wsm_pkg::RegPat0: prdata = pat_q[0];
      wsm_pkg::RegPat1: prdata = pat_q[1];
      wsm_pkg::RegPat2: prdata = pat_q[2];
      wsm_pkg::RegPat3: prdata = pat_q[3];
      wsm_pkg::RegLen:  prdata = wsm_pkg::CfgDataW'(len_q);
      wsm_pkg::RegFold: prdata = wsm_pkg::CfgDataW'(fold_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.pattern   = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};
  assign cfg_o.length    = len_q;
  assign cfg_o.fold_case = fold_q;

endmodule

// File: sv/wsm_hit_mask.sv
// ---------------------------------------------------------------------------
// Per-position hit mask
// Compares one text byte against every active pattern byte in parallel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsm_hit_mask #(
  parameter int VecW = wsm_pkg::PatternBytes
) (
  input  wsm_pkg::wsm_cfg_t         cfg_i,
  input  logic [wsm_pkg::LenW-1:0]  len_eff_i,
  input  logic [7:0]                text_byte_i,
  output logic [VecW-1:0]           mask_o
);

  logic [7:0] text_lc;

  assign text_lc = wsm_pkg::lower_byte(text_byte_i, cfg_i.fold_case);

  // One comparator lane per pattern position. A dot matches anything but a space.
  always_comb begin
    logic [7:0] p;
    logic       hit;
    for (int j = 0; j < VecW; j++) begin
      p   = cfg_i.pattern[8*j +: 8];
      hit = (p == wsm_pkg::DotChar) ? (text_byte_i != wsm_pkg::SpaceChar)
                                    : (wsm_pkg::lower_byte(p, cfg_i.fold_case) == text_lc);
      mask_o[j] = hit & (wsm_pkg::LenW'(j) < len_eff_i);
    end
  end

endmodule

// File: sv/wsm_core.sv
// ---------------------------------------------------------------------------
// Shift-and match core
// Holds the partial-match vector, the line position and the first match,
// and produces the result word on the last byte of a line.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_substring_matcher_top_macros.svh"

module wsm_core #(
  parameter int MaxPattern = wsm_pkg::MaxPatternDefault,
  parameter int MaxText    = wsm_pkg::MaxTextDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wsm_pkg::wsm_cfg_t      cfg_i,
  input  logic                   fire_i,
  input  wsm_pkg::wsm_in_word_t  word_i,
  output wsm_pkg::wsm_out_word_t result_o
);

  localparam int VecW = (MaxPattern < wsm_pkg::PatternBytes) ? MaxPattern
                                                             : wsm_pkg::PatternBytes;
  localparam int PosW = $clog2(MaxText + 1);

  logic [VecW-1:0]                vec_q, vec_d, vec_shift, mask, last_sel;
  logic [PosW-1:0]                pos_q, pos_d;
  logic                           found_q, found_d;
  logic [wsm_pkg::PosOutW-1:0]    start_q, start_d;
  logic [wsm_pkg::LenW-1:0]       len_eff;
  logic                           searching;

  // Clamp the programmed length to the pattern capacity.
  assign len_eff = (cfg_i.length > wsm_pkg::LenW'(VecW)) ? wsm_pkg::LenW'(VecW)
                                                         : cfg_i.length;

  wsm_hit_mask #(
    .VecW (VecW)
  ) u_hit_mask (
    .cfg_i       (cfg_i),
    .len_eff_i   (len_eff),
    .text_byte_i (word_i.text_byte),
    .mask_o      (mask)
  );

  // One-hot select of the bit that marks a complete match.
  always_comb begin
    for (int j = 0; j < VecW; j++) begin
      last_sel[j] = (len_eff == wsm_pkg::LenW'(j + 1));
    end
  end

  assign vec_shift = (vec_q << 1) | VecW'(1);
  assign searching = (pos_q < PosW'(MaxText));

  // Next state for the byte being processed.
  always_comb begin
    vec_d   = vec_q;
    pos_d   = pos_q;
    found_d = found_q;
    start_d = start_q;
    if (searching) begin
      vec_d = vec_shift & mask;
      pos_d = pos_q + PosW'(1);
      if (!found_q) begin
        if (len_eff == '0) begin
          found_d = 1'b1;
          start_d = '0;
        end else if (|(vec_d & last_sel)) begin
          found_d = 1'b1;
          start_d = wsm_pkg::PosOutW'(pos_q) + wsm_pkg::PosOutW'(1)
                    - wsm_pkg::PosOutW'(len_eff);
        end
      end
    end
  end

  // Result word for a line that ends with this byte.
  assign result_o.match_found    = found_d;
  assign result_o.match_position = found_d ? start_d : '0;

  // Line state; cleared after the last byte of each line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      start_q <= '0;
    end else if (fire_i) begin
      if (word_i.line_end) begin
        vec_q   <= '0;
        pos_q   <= '0;
        found_q <= 1'b0;
        start_q <= '0;
      end else begin
        vec_q   <= vec_d;
        pos_q   <= pos_d;
        found_q <= found_d;
        start_q <= start_d;
      end
    end
  end

  `WSM_ASSERT_NEXT(a_line_clear, fire_i && word_i.line_end, (pos_q == '0) && (vec_q == '0) && !found_q, "line state not cleared after last byte")
  `WSM_ASSERT_NEXT(a_found_sticky, found_q && !(fire_i && word_i.line_end), found_q, "first match lost within a line")
  `WSM_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= PosW'(MaxText), "position counter past its limit")

endmodule

// File: sv/wildcard_substring_matcher_top.sv
// ---------------------------------------------------------------------------
// Wildcard substring matcher: one text byte per cycle, one result word per line.
// Result word: registered, loaded as the last byte of its line leaves the input register.
// Throughput: one byte per cycle; stalls only when a held line end meets a blocked result.
// Reset: asynchronous, active low; clears config registers, line state and valids.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_substring_matcher_top_macros.svh"

module wildcard_substring_matcher_top #(
  parameter int MaxPattern = wsm_pkg::MaxPatternDefault,
  parameter int MaxText    = wsm_pkg::MaxTextDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [wsm_pkg::CfgDataW-1:0]  pwdata,
  output logic [wsm_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  // Text input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wsm_pkg::wsm_in_word_t         in_word_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wsm_pkg::wsm_out_word_t        out_word_o
);

  wsm_pkg::wsm_cfg_t      cfg;
  wsm_pkg::wsm_out_word_t result;
  wsm_pkg::wsm_in_word_t  in_word_q;
  wsm_pkg::wsm_out_word_t out_word_q;
  logic                   in_valid_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_accept;

  wsm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held word moves on unless it ends a line and the result slot is blocked.
  assign advance    = in_valid_q & ~(in_word_q.line_end & out_valid_q & out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  wsm_core #(
    .MaxPattern (MaxPattern),
    .MaxText    (MaxText)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (advance),
    .word_i   (in_word_q),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_word_q.line_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_word_q.line_end) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `WSM_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i && in_word_q.line_end, "input stalled without a blocked result")
  `WSM_ASSERT_IMP(a_nomatch_zero, out_valid_o && !out_word_o.match_found, out_word_o.match_position == '0, "position nonzero without a match")
  `WSM_ASSERT_NEXT(a_end_result, advance && in_word_q.line_end, out_valid_o, "line end produced no result")

endmodule

// File: tb/wildcard_substring_matcher_top_test.sv
// ---------------------------------------------------------------------------
// Wildcard substring matcher testbench
// Streams lines of text through the matcher and checks the match result of
// every line against a line-by-line shift-and predictor kept in a small
// scoreboard class. A few directed lines come first. Then random phases
// follow, each with its own pattern and case setting, where most lines carry
// a planted copy of the pattern. Both sides of the stream idle and stall at
// random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_substring_matcher_top_test;

  localparam int MaxPattern   = wsm_pkg::MaxPatternDefault;
  localparam int MaxText      = wsm_pkg::MaxTextDefault;
  localparam int UnusedReg    = 6;
  localparam int DrainCycles  = 6;
  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 850;
  localparam int NumTextChars = 7;
  localparam bit [NumTextChars*8-1:0] TextChars = {"a", "b", "c", "A", "B",
                                                   wsm_pkg::DotChar, wsm_pkg::SpaceChar};

  // Predicts the result of each line and checks the words that come back.
  class line_match_scoreboard;
    bit [63:0]                pattern_words [4];
    bit [wsm_pkg::LenW-1:0]   length_field;
    bit                       fold;
    bit [31:0]                partial;
    bit [8:0]                 position;
    bit                       found;
    bit [7:0]                 found_start;
    wsm_pkg::wsm_out_word_t   expected_matches [$];
    int                       errors;
    int                       lines;
    int                       hits;

    function void write_reg(int idx, bit [63:0] value);
      case (idx)
        wsm_pkg::RegPat0, wsm_pkg::RegPat1, wsm_pkg::RegPat2, wsm_pkg::RegPat3:
          pattern_words[idx[1:0]] = value;
        wsm_pkg::RegLen:  length_field = value[wsm_pkg::LenW-1:0];
        wsm_pkg::RegFold: fold = value[0];
        default: ;
      endcase
    endfunction

    function bit [7:0] fold_letter(bit [7:0] c);
      if (fold && c >= wsm_pkg::UpperA && c <= wsm_pkg::UpperZ) begin
        return c | wsm_pkg::CaseBit;
      end
      return c;
    endfunction

    // Note one accepted text word and queue the line result on its last word.
    function void take_byte(wsm_pkg::wsm_in_word_t w);
      int                     n;
      int                     first;
      bit [31:0]              hit_mask;
      bit [7:0]               p;
      wsm_pkg::wsm_out_word_t r;
      n = length_field;
      if (n > wsm_pkg::PatternBytes) n = wsm_pkg::PatternBytes;
      if (n > MaxPattern) n = MaxPattern;
      // Bytes past the search window leave the match state alone.
      if (position < MaxText) begin
        hit_mask = '0;
        for (int j = 0; j < n; j++) begin
          p = pattern_words[j / 8][(j % 8) * 8 +: 8];
          if (p == wsm_pkg::DotChar) begin
            hit_mask[j] = (w.text_byte != wsm_pkg::SpaceChar);
          end else begin
            hit_mask[j] = (fold_letter(p) == fold_letter(w.text_byte));
          end
        end
        partial = ((partial << 1) | 32'd1) & hit_mask;
        // Only the first match of a line counts.
        if (!found) begin
          if (n == 0) begin
            found = 1'b1;
            found_start = '0;
          end else if (partial[n-1]) begin
            found = 1'b1;
            first = int'(position) + 1 - n;
            found_start = first[7:0];
          end
        end
        position++;
      end
      if (w.line_end) begin
        r.match_found = found;
        r.match_position = found ? found_start : '0;
        expected_matches.push_back(r);
        lines++;
        if (found) hits++;
        partial = '0;
        position = '0;
        found = 1'b0;
        found_start = '0;
      end
    endfunction

    function void check_match(wsm_pkg::wsm_out_word_t got);
      wsm_pkg::wsm_out_word_t want;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: found %0d position %0d",
                 $time, got.match_found, got.match_position);
        return;
      end
      want = expected_matches.pop_front();
      if (got.match_found !== want.match_found) begin
        errors++;
        $display("%0t: match_found expected %0d actual %0d",
                 $time, want.match_found, got.match_found);
      end
      if (got.match_position !== want.match_position) begin
        errors++;
        $display("%0t: match_position expected %0d actual %0d",
                 $time, want.match_position, got.match_position);
      end
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [wsm_pkg::CfgAddrW-1:0] paddr;
  logic [wsm_pkg::CfgDataW-1:0] pwdata;
  logic [wsm_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_stall_o;
  wsm_pkg::wsm_in_word_t        in_word_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  wsm_pkg::wsm_out_word_t       out_word_o;

  line_match_scoreboard board = new();

  bit        tx_idle;
  bit        rx_idle;
  int        cycles;
  int        settings;
  int        sent_words;
  int        active_len;
  bit        active_fold;
  bit [7:0]  pattern_text [wsm_pkg::PatternBytes];
  bit [7:0]  line_text [$];

  wildcard_substring_matcher_top u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: hold off for a random number of cycles, then take one word.
  initial begin
    int holdoff;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      holdoff = rx_idle ? $urandom_range(0, 10) : 0;
      if (holdoff > 0) begin
        out_stall_i <= 1'b1;
        repeat (holdoff) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_match(out_word_o);
    end
  end

  function automatic bit [7:0] rand_text_char();
    if ($urandom_range(0, 9) < 8) begin
      return TextChars[$urandom_range(0, NumTextChars - 1) * 8 +: 8];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // A text byte that the active pattern byte accepts.
  function automatic bit [7:0] planted_byte(bit [7:0] p);
    bit [7:0] c;
    if (p == wsm_pkg::DotChar) begin
      do c = rand_text_char(); while (c == wsm_pkg::SpaceChar);
      return c;
    end
    if (!active_fold) return p;
    c = (p >= wsm_pkg::UpperA && p <= wsm_pkg::UpperZ) ? (p | wsm_pkg::CaseBit) : p;
    if (c >= (wsm_pkg::UpperA | wsm_pkg::CaseBit) && c <= (wsm_pkg::UpperZ | wsm_pkg::CaseBit)
        && $urandom_range(0, 1) == 1) begin
      c = c & ~wsm_pkg::CaseBit;
    end
    return c;
  endfunction

  // Send one text word after a random gap and wait until it is taken.
  task automatic send_word(input bit [7:0] text_byte, input bit line_end);
    int                    gap;
    wsm_pkg::wsm_in_word_t w;
    w.text_byte = text_byte;
    w.line_end = line_end;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.take_byte(w);
    sent_words++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_text.size(); i++) begin
      send_word(line_text[i], i == line_text.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_text.delete();
    for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    send_line();
  endtask

  // Stop sending, let every expected result come back, then let the
  // pipeline empty of words that end no line.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input bit [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= wsm_pkg::CfgAddrW'(idx * 8);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    board.write_reg(idx, value);
  endtask

  // Write all pattern words, the length and the case setting.
  task automatic program_pattern(input bit [wsm_pkg::LenW-1:0] len_field, input bit fold_bit);
    bit [63:0] word;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pattern_text[w * 8 + b];
      write_reg(wsm_pkg::RegPat0 + w, word);
    end
    write_reg(wsm_pkg::RegLen, 64'(len_field));
    write_reg(wsm_pkg::RegFold, 64'(fold_bit));
    active_len = len_field;
    if (active_len > wsm_pkg::PatternBytes) active_len = wsm_pkg::PatternBytes;
    if (active_len > MaxPattern) active_len = MaxPattern;
    active_fold = fold_bit;
    settings++;
  endtask

  task automatic program_text_pattern(input string s, input bit fold_bit);
    for (int j = 0; j < wsm_pkg::PatternBytes; j++) begin
      pattern_text[j] = (j < s.len()) ? s[j] : 8'h00;
    end
    program_pattern(wsm_pkg::LenW'(s.len()), fold_bit);
  endtask

  // Random line, mostly short; most lines carry a copy of the pattern.
  // Long lines place the copy around the end of the search window.
  task automatic send_random_line();
    int k;
    int len;
    int start;
    k = $urandom_range(0, 29);
    if (k == 0) len = $urandom_range(250, 300);
    else if (k < 5) len = $urandom_range(1, 3);
    else len = $urandom_range(4, 20);
    line_text.delete();
    for (int i = 0; i < len; i++) line_text.push_back(rand_text_char());
    if (active_len > 0 && $urandom_range(0, 9) < 6) begin
      if (len < active_len) begin
        len = active_len + $urandom_range(0, 8);
        while (line_text.size() < len) line_text.push_back(rand_text_char());
      end
      if (k == 0) begin
        start = MaxText - active_len - 2 + int'($urandom_range(0, 4));
        if (start > len - active_len) start = len - active_len;
        if (start < 0) start = 0;
      end else begin
        start = $urandom_range(0, len - active_len);
      end
      for (int j = 0; j < active_len; j++) begin
        line_text[start + j] = planted_byte(pattern_text[j]);
      end
    end
    send_line();
  endtask

  initial begin
    int                      phase;
    int                      start_words;
    int                      phase_end;
    int                      k;
    bit [wsm_pkg::LenW-1:0]  len_field;
    bit                      fold_bit;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern after reset matches at the start, extreme byte values.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b1);
    drain_block();

    // Dot does not match a space; folded match; a later match is ignored.
    program_text_pattern("A.c", 1'b1);
    send_text("a cxaBCabc");
    drain_block();

    // Exact case: first line misses, second line matches at the start.
    write_reg(wsm_pkg::RegFold, 64'd0);
    active_fold = 1'b0;
    send_text("aBc");
    send_text("ABc");
    drain_block();

    // A literal space in the pattern matches only a space.
    program_text_pattern(" a", 1'b0);
    send_text("a a");

    // Random phases, each with a fresh pattern setting.
    start_words = sent_words;
    phase = 0;
    while (sent_words - start_words < RandomItems) begin
      drain_block();
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 4) != 1;
      for (int j = 0; j < wsm_pkg::PatternBytes; j++) pattern_text[j] = rand_text_char();
      fold_bit = $urandom_range(0, 1);
      k = $urandom_range(0, 9);
      if (phase == 0) begin
        len_field = wsm_pkg::LenW'(wsm_pkg::PatternBytes);
        fold_bit = 1'b1;
      end else if (phase == 1) begin
        // All-ones pattern with the largest length field.
        for (int j = 0; j < wsm_pkg::PatternBytes; j++) pattern_text[j] = 8'hFF;
        len_field = '1;
        fold_bit = 1'b0;
      end else if (phase == 2) begin
        for (int j = 0; j < wsm_pkg::PatternBytes; j++) pattern_text[j] = 8'h00;
        len_field = 2;
      end else if (k == 0) begin
        len_field = '0;
      end else if (k == 1) begin
        len_field = wsm_pkg::LenW'($urandom_range(33, 63));
      end else if (k == 2) begin
        len_field = wsm_pkg::LenW'($urandom_range(7, 32));
      end else begin
        len_field = wsm_pkg::LenW'($urandom_range(1, 6));
      end
      program_pattern(len_field, fold_bit);
      // Writes to an unused register index must change nothing.
      if (phase == 3) write_reg(UnusedReg, {$urandom, $urandom});
      phase_end = sent_words + $urandom_range(40, 100);
      while (sent_words < phase_end) begin
        send_random_line();
        if ($urandom_range(0, 9) == 0) drain_block();
      end
      phase++;
    end
    drain_block();

    $display("Sent %0d text words in %0d lines under %0d pattern settings.",
             sent_words, board.lines, settings);
    $display("%0d lines reported a match; %0d mismatches seen.", board.hits, board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/wsm_pkg.sv
sv/wsm_cfg_regs.sv
sv/wsm_hit_mask.sv
sv/wsm_core.sv
sv/wildcard_substring_matcher_top.sv
tb/wildcard_substring_matcher_top_test.sv
